// ===== design/i2cms_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// i2cms_pkg
// Shared types and constants for the I2C slave memory unit.
// ----------------------------------------------------------------------------
package i2cms_pkg;

   // default memory depth in bytes
   localparam int MEM_DEPTH_DEF = 4096;

   localparam int CMD_W       = 2;
   localparam int BYTE_W      = 8;
   localparam int SLAVE_W     = 7;
   localparam int MSIZE_W     = 13;
   localparam int BASE_W      = 16;
   localparam int COUNT_W     = 17;
   localparam int CSR_INDEX_W = 1;
   localparam int CSR_DATA_W  = 13;

   // register reset values
   localparam logic [SLAVE_W-1:0] SLAVE_ADDRESS_RESET = 7'd80;
   localparam logic [MSIZE_W-1:0] MEMORY_SIZE_RESET   = 13'd4096;

   // register indexes
   localparam logic [CSR_INDEX_W-1:0] CSR_SLAVE_ADDRESS = 1'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_MEMORY_SIZE   = 1'd1;

   // bus event codes
   typedef enum logic [CMD_W-1:0] {
      CMD_START = 2'd0,
      CMD_STOP  = 2'd1,
      CMD_BYTE  = 2'd2
   } cmd_type;

   // transaction phase
   typedef enum logic [2:0] {
      PH_IDLE      = 3'd0,
      PH_ADDRESSED = 3'd1,
      PH_ADR_HIGH  = 3'd2,
      PH_ADR_LOW   = 3'd3,
      PH_XFER      = 3'd4
   } phase_type;

   typedef struct packed {
      logic [CMD_W-1:0]  command;
      logic [BYTE_W-1:0] data_byte;
   } req_payload_type;

   typedef struct packed {
      logic              ack;
      logic [BYTE_W-1:0] return_byte;
   } rsp_payload_type;

   typedef struct packed {
      logic [SLAVE_W-1:0] slave_address;
      logic [MSIZE_W-1:0] memory_size;
   } cfg_type;

   // per-beat decision from the protocol engine
   typedef struct packed {
      logic              ack;
      logic              mem_wr;
      logic              mem_rd;
      logic [BYTE_W-1:0] echo_byte;
   } mem_ctl_type;

endpackage

// ===== design/i2cms_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// i2cms_ram
// Generic simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module i2cms_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 4096,
   localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== design/i2cms_engine.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// i2cms_engine
// Bus protocol engine: phase tracking, address capture and bounds checks.
// ----------------------------------------------------------------------------
module i2cms_engine
   import i2cms_pkg::*;
#(
   parameter int MEM_DEPTH = MEM_DEPTH_DEF,
   localparam int AW       = (MEM_DEPTH > 1) ? $clog2(MEM_DEPTH) : 1
) (
   input  logic            clock,
   input  logic            reset,
   input  logic            fire,
   input  req_payload_type req,
   input  cfg_type         cfg,
   output mem_ctl_type     ctl,
   output logic [AW-1:0]   mem_addr
);

   localparam logic [COUNT_W-1:0] DEPTH_V = COUNT_W'(MEM_DEPTH);

   phase_type           phase_ff, phase_in;
   logic                write_mode_ff, write_mode_in;
   logic [BASE_W-1:0]   base_ff, base_in;
   logic [COUNT_W-1:0]  count_ff, count_in;

   logic [COUNT_W:0]    eff_addr;
   logic [COUNT_W-1:0]  size_ext;
   logic [COUNT_W-1:0]  bound;
   logic                in_range;
   logic                addr_match;
   logic [BASE_W-1:0]   base_low;

   // effective address and bounds
   always_comb begin
      eff_addr   = {2'b00, base_ff} + {1'b0, count_ff};
      size_ext   = {{(COUNT_W-MSIZE_W){1'b0}}, cfg.memory_size};
      bound      = (size_ext < DEPTH_V) ? size_ext : DEPTH_V;
      in_range   = eff_addr < {1'b0, bound};
      addr_match = req.data_byte[BYTE_W-1:1] == cfg.slave_address;
      base_low   = base_ff | {{(BASE_W-BYTE_W){1'b0}}, req.data_byte};
   end

   assign mem_addr = eff_addr[AW-1:0];

   // next phase
   always_comb begin
      phase_in = phase_ff;
      if (fire) begin
         case (req.command)
            CMD_START: begin
               if (phase_ff == PH_IDLE) phase_in = PH_ADDRESSED;
            end
            CMD_STOP: begin
               phase_in = PH_IDLE;
            end
            CMD_BYTE: begin
               case (phase_ff)
                  PH_ADDRESSED: phase_in = addr_match ? PH_ADR_HIGH : PH_IDLE;
                  PH_ADR_HIGH:  phase_in = PH_ADR_LOW;
                  PH_ADR_LOW:   phase_in = PH_XFER;
                  default:      phase_in = phase_ff;
               endcase
            end
            default: phase_in = phase_ff;
         endcase
      end
   end

   // beat outputs and transfer state updates
   always_comb begin
      ctl           = '0;
      write_mode_in = write_mode_ff;
      base_in       = base_ff;
      count_in      = count_ff;
      case (req.command)
         CMD_START: begin
            ctl.ack       = 1'b1;
            write_mode_in = 1'b0;
            base_in       = '0;
            count_in      = '0;
         end
         CMD_STOP: begin
            ctl.ack = 1'b1;
         end
         CMD_BYTE: begin
            case (phase_ff)
               PH_ADDRESSED: begin
                  if (addr_match) begin
                     ctl.ack       = 1'b1;
                     write_mode_in = req.data_byte[0];
                     base_in       = '0;
                     count_in      = '0;
                  end
               end
               PH_ADR_HIGH: begin
                  ctl.ack = 1'b1;
                  base_in = {req.data_byte, {BYTE_W{1'b0}}};
               end
               PH_ADR_LOW: begin
                  base_in = base_low;
                  ctl.ack = base_low < {{(BASE_W-MSIZE_W){1'b0}}, cfg.memory_size};
               end
               PH_XFER: begin
                  if (in_range) begin
                     ctl.ack    = 1'b1;
                     ctl.mem_wr = write_mode_ff;
                     ctl.mem_rd = !write_mode_ff;
                     if (write_mode_ff) ctl.echo_byte = req.data_byte;
                     count_in   = count_ff + 1'b1;
                  end
               end
               default: ctl = '0;
            endcase
         end
         default: ctl = '0;
      endcase
      // memory access only on an accepted beat
      ctl.mem_wr = ctl.mem_wr & fire;
      ctl.mem_rd = ctl.mem_rd & fire;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff      <= PH_IDLE;
         write_mode_ff <= 1'b0;
         base_ff       <= '0;
         count_ff      <= '0;
      end else begin
         phase_ff <= phase_in;
         if (fire) begin
            write_mode_ff <= write_mode_in;
            base_ff       <= base_in;
            count_ff      <= count_in;
         end
      end
   end

endmodule

// ===== design/i2c_memory_slave_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// i2c_memory_slave_unit
// I2C slave memory with a 16-bit memory address, driven by bus events.
// ----------------------------------------------------------------------------
// One bus event (start, stop or byte) is taken per cycle while the result side
// keeps up; each beat gives one result, passing through the memory stage,
// which holds the registered read port of the byte memory, and then the output
// register. After reset a clearing pass writes zero to every memory byte, during
// which req_stall stays high; register writes are taken throughout.
module i2c_memory_slave_unit
   import i2cms_pkg::*;
#(
   parameter int MEM_DEPTH = MEM_DEPTH_DEF
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  req_payload_type        req_payload,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output rsp_payload_type        rsp_payload,
   input  logic                   csr_wr_en,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata
);

   localparam int AW = (MEM_DEPTH > 1) ? $clog2(MEM_DEPTH) : 1;
   localparam logic [AW-1:0] LAST_ADDR = AW'(MEM_DEPTH - 1);

   cfg_type           cfg_ff;
   logic              clear_ff;
   logic [AW-1:0]     clear_addr_ff;
   logic              fire;
   mem_ctl_type       ctl;
   logic [AW-1:0]     mem_addr;
   logic              ram_wr_en;
   logic [AW-1:0]     ram_wr_addr;
   logic [BYTE_W-1:0] ram_wr_data;
   logic [BYTE_W-1:0] ram_rd_data;

   logic              pend_ff;
   logic              pend_ack_ff;
   logic              pend_rd_ff;
   logic [BYTE_W-1:0] pend_byte_ff;
   logic              pend_move;

   logic              rsp_valid_ff;
   rsp_payload_type   rsp_ff;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.slave_address <= SLAVE_ADDRESS_RESET;
         cfg_ff.memory_size   <= MEMORY_SIZE_RESET;
      end else if (csr_wr_en) begin
         case (csr_index)
            CSR_SLAVE_ADDRESS: cfg_ff.slave_address <= csr_wdata[SLAVE_W-1:0];
            CSR_MEMORY_SIZE:   cfg_ff.memory_size   <= csr_wdata[MSIZE_W-1:0];
            default:           cfg_ff <= cfg_ff;
         endcase
      end
   end

   // clearing pass after reset
   always_ff @(posedge clock) begin
      if (reset) begin
         clear_ff      <= 1'b1;
         clear_addr_ff <= '0;
      end else if (clear_ff) begin
         clear_addr_ff <= clear_addr_ff + 1'b1;
         if (clear_addr_ff == LAST_ADDR) clear_ff <= 1'b0;
      end
   end

   // input handshake: one beat may sit in the memory stage
   assign pend_move = pend_ff && (!rsp_valid_ff || !rsp_stall);
   assign req_stall = clear_ff || (pend_ff && !pend_move);
   assign fire      = req_valid && !req_stall;

   i2cms_engine #(
      .MEM_DEPTH (MEM_DEPTH)
   ) u_engine (
      .clock    (clock),
      .reset    (reset),
      .fire     (fire),
      .req      (req_payload),
      .cfg      (cfg_ff),
      .ctl      (ctl),
      .mem_addr (mem_addr)
   );

   assign ram_wr_en   = clear_ff || ctl.mem_wr;
   assign ram_wr_addr = clear_ff ? clear_addr_ff : mem_addr;
   assign ram_wr_data = clear_ff ? '0 : req_payload.data_byte;

   i2cms_ram #(
      .WIDTH (BYTE_W),
      .DEPTH (MEM_DEPTH)
   ) u_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ctl.mem_rd),
      .rd_addr (mem_addr),
      .rd_data (ram_rd_data)
   );

   // memory stage
   always_ff @(posedge clock) begin
      if (reset) begin
         pend_ff <= 1'b0;
      end else if (fire) begin
         pend_ff <= 1'b1;
      end else if (pend_move) begin
         pend_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (fire) begin
         pend_ack_ff  <= ctl.ack;
         pend_rd_ff   <= ctl.mem_rd;
         pend_byte_ff <= ctl.echo_byte;
      end
   end

   // output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (pend_move) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (pend_move) begin
         rsp_ff.ack         <= pend_ack_ff;
         rsp_ff.return_byte <= pend_rd_ff ? ram_rd_data : pend_byte_ff;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

endmodule

// ===== design/i2cms_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// i2cms_checker
// Port-level checks for the I2C slave memory unit, bound to the top level.
// ----------------------------------------------------------------------------
module i2cms_checker
   import i2cms_pkg::*;
(
   input logic            clock,
   input logic            reset,
   input logic            req_valid,
   input logic            req_stall,
   input req_payload_type req_payload,
   input logic            rsp_valid,
   input logic            rsp_stall,
   input rsp_payload_type rsp_payload
);

   // the clearing pass holds off input right after reset
   a_clear_stall: assert property (@(posedge clock) reset |=> req_stall)
      else $error("input not stalled after reset");

   // a beat taken with the output empty shows its result after the memory stage and output register
   a_latency: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall && !rsp_valid) |=> ##1 rsp_valid)
      else $error("result missing after accepted beat");

   // a not-acknowledged result never carries data
   a_nak_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_payload.ack) |-> (rsp_payload.return_byte == '0))
      else $error("data on not-acknowledged result");

   // a stalled result beat is held
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> (rsp_valid && $stable(rsp_payload)))
      else $error("stalled result dropped or changed");

endmodule

bind i2c_memory_slave_unit i2cms_checker u_checker (.*);

// ===== bench/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the I2C slave memory unit.
// ----------------------------------------------------------------------------
// Bus events (start, stop, bytes) are sent in bursts with random gaps. A
// scoreboard keeps its own copy of the device state and byte memory, works
// out the expected ack and return byte for every accepted event, and compares
// each result beat in order. The run opens with a short directed sequence
// covering the corner cases. It then runs phases of random, mostly
// well-formed transactions under changing address and size settings, and
// the result side stalls on a pattern of its own.
// ----------------------------------------------------------------------------
module testbench;
   import i2cms_pkg::*;

   localparam int EVENT_TARGET   = 850;
   localparam int DRAIN_CYCLES   = 6;
   localparam int WATCHDOG_LIMIT = 20000;

   // command code the block must ignore
   localparam logic [CMD_W-1:0] CMD_UNKNOWN = 2'd3;

   typedef enum logic [1:0] {
      STALL_NONE,
      STALL_LIGHT,
      STALL_HEAVY,
      STALL_PERIODIC
   } stall_mode_type;

   // -------------------------------------------------------------------------
   // Scoreboard: a copy of the slave state, plus the queue of pending results
   // -------------------------------------------------------------------------
   class i2c_memory_scoreboard;
      logic [SLAVE_W-1:0] slave_addr;
      logic [MSIZE_W-1:0] mem_size;
      phase_type          phase;
      logic               write_mode;
      logic [BASE_W-1:0]  base_addr;
      logic [COUNT_W-1:0] xfer_count;
      logic [BYTE_W-1:0]  mem_image [MEM_DEPTH_DEF];
      rsp_payload_type    expected_q[$];
      int error_count;
      int event_count;
      int ack_count;
      int write_count;
      int read_count;

      function new();
         slave_addr  = SLAVE_ADDRESS_RESET;
         mem_size    = MEMORY_SIZE_RESET;
         phase       = PH_IDLE;
         write_mode  = 1'b0;
         base_addr   = '0;
         xfer_count  = '0;
         error_count = 0;
         event_count = 0;
         ack_count   = 0;
         write_count = 0;
         read_count  = 0;
         for (int i = 0; i < MEM_DEPTH_DEF; i++) mem_image[i] = '0;
      endfunction

      function void write_register(logic [CSR_INDEX_W-1:0] idx,
                                   logic [CSR_DATA_W-1:0] value);
         if (idx == CSR_SLAVE_ADDRESS)
            slave_addr = value[SLAVE_W-1:0];
         else if (idx == CSR_MEMORY_SIZE)
            mem_size = value[MSIZE_W-1:0];
      endfunction

      // work out the result of one accepted bus event
      function void note_request(req_payload_type req);
         rsp_payload_type res;
         int eff;
         int limit;
         res.ack         = 1'b0;
         res.return_byte = '0;
         if (req.command != CMD_UNKNOWN) event_count++;
         case (req.command)
            CMD_START: begin
               // a repeated start keeps the phase but clears the transfer
               if (phase == PH_IDLE) phase = PH_ADDRESSED;
               write_mode = 1'b0;
               base_addr  = '0;
               xfer_count = '0;
               res.ack    = 1'b1;
            end
            CMD_STOP: begin
               phase   = PH_IDLE;
               res.ack = 1'b1;
            end
            CMD_BYTE: begin
               case (phase)
                  PH_ADDRESSED: begin
                     if (req.data_byte[7:1] == slave_addr) begin
                        write_mode = req.data_byte[0];
                        base_addr  = '0;
                        xfer_count = '0;
                        phase      = PH_ADR_HIGH;
                        res.ack    = 1'b1;
                     end else begin
                        phase = PH_IDLE;
                     end
                  end
                  PH_ADR_HIGH: begin
                     base_addr = {req.data_byte, 8'h00};
                     phase     = PH_ADR_LOW;
                     res.ack   = 1'b1;
                  end
                  PH_ADR_LOW: begin
                     base_addr = base_addr | {8'h00, req.data_byte};
                     phase     = PH_XFER;
                     // checked against the raw size, not the clipped limit
                     res.ack   = (int'(base_addr) < int'(mem_size));
                  end
                  PH_XFER: begin
                     eff   = int'(base_addr) + int'(xfer_count);
                     limit = (int'(mem_size) < MEM_DEPTH_DEF) ? int'(mem_size)
                                                              : MEM_DEPTH_DEF;
                     if (eff < limit) begin
                        if (write_mode) begin
                           mem_image[eff]  = req.data_byte;
                           res.return_byte = req.data_byte;
                           write_count++;
                        end else begin
                           res.return_byte = mem_image[eff];
                           read_count++;
                        end
                        xfer_count = xfer_count + 1'b1;
                        res.ack    = 1'b1;
                     end
                  end
                  default: ;
               endcase
            end
            default: ;
         endcase
         if (res.ack) ack_count++;
         expected_q.push_back(res);
      endfunction

      task report_mismatch(string msg);
         $display("[%0t] MISMATCH: %s", $time, msg);
         error_count++;
      endtask

      // compare one result beat with the oldest pending expectation
      task check_response(rsp_payload_type rsp);
         rsp_payload_type exp_rsp;
         if (expected_q.size() == 0) begin
            report_mismatch($sformatf("unexpected result ack=%0b byte=%02h",
                                      rsp.ack, rsp.return_byte));
         end else begin
            exp_rsp = expected_q.pop_front();
            if (rsp.ack !== exp_rsp.ack)
               report_mismatch($sformatf("ack got %0b want %0b",
                                         rsp.ack, exp_rsp.ack));
            if (rsp.return_byte !== exp_rsp.return_byte)
               report_mismatch($sformatf("return_byte got %02h want %02h",
                                         rsp.return_byte, exp_rsp.return_byte));
         end
      endtask
   endclass

   // -------------------------------------------------------------------------
   // Signals and device
   // -------------------------------------------------------------------------
   logic                   clock       = 1'b0;
   logic                   reset       = 1'b1;
   logic                   req_valid   = 1'b0;
   logic                   req_stall;
   req_payload_type        req_payload = '0;
   logic                   rsp_valid;
   logic                   rsp_stall   = 1'b0;
   rsp_payload_type        rsp_payload;
   logic                   csr_wr_en   = 1'b0;
   logic [CSR_INDEX_W-1:0] csr_index   = '0;
   logic [CSR_DATA_W-1:0]  csr_wdata   = '0;

   i2c_memory_scoreboard board = new();
   req_payload_type      stim_q[$];
   int                   settings_count = 0;

   i2c_memory_slave_unit dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload),
      .csr_wr_en   (csr_wr_en),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // -------------------------------------------------------------------------
   // Result side: check each beat, stall on a changing pattern
   // -------------------------------------------------------------------------
   stall_mode_type stall_mode = STALL_NONE;
   int             stall_left = 0;
   int             stall_tick = 0;

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) board.check_response(rsp_payload);
      if (stall_left == 0) begin
         stall_mode = stall_mode_type'($urandom_range(0, 3));
         stall_left = $urandom_range(20, 200);
      end else begin
         stall_left--;
      end
      stall_tick++;
      case (stall_mode)
         STALL_LIGHT:    rsp_stall <= ($urandom_range(0, 3) == 0);
         STALL_HEAVY:    rsp_stall <= ($urandom_range(0, 9) < 6);
         STALL_PERIODIC: rsp_stall <= (stall_tick % 3 == 0);
         default:        rsp_stall <= 1'b0;
      endcase
   end

   // -------------------------------------------------------------------------
   // Watchdog: too long with no beat on either channel ends the run
   // -------------------------------------------------------------------------
   int idle_cycles = 0;

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall))
         idle_cycles = 0;
      else
         idle_cycles++;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("[%0t] watchdog: no beat for %0d cycles", $time, idle_cycles);
         $display("*** FAILED ***");
         $finish;
      end
   end

   // -------------------------------------------------------------------------
   // Stimulus helpers
   // -------------------------------------------------------------------------
   function automatic void queue_event(logic [CMD_W-1:0] cmd, logic [BYTE_W-1:0] b);
      req_payload_type p;
      p.command   = cmd;
      p.data_byte = b;
      stim_q.push_back(p);
   endfunction

   task automatic write_csr(logic [CSR_INDEX_W-1:0] idx, logic [CSR_DATA_W-1:0] value);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
      board.write_register(idx, value);
      csr_wr_en <= 1'b0;
      @(posedge clock);
   endtask

   task automatic program_registers(logic [SLAVE_W-1:0] slave, logic [MSIZE_W-1:0] size);
      write_csr(CSR_SLAVE_ADDRESS, CSR_DATA_W'(slave));
      write_csr(CSR_MEMORY_SIZE, size);
      settings_count++;
   endtask

   // send the queued events in bursts separated by random gaps
   task automatic send_events();
      int burst_left;
      int gap_left;
      burst_left = $urandom_range(1, 24);
      gap_left   = 0;
      while (stim_q.size() > 0) begin
         if (gap_left > 0) begin
            req_valid <= 1'b0;
            gap_left--;
            @(posedge clock);
         end else begin
            req_valid   <= 1'b1;
            req_payload <= stim_q[0];
            @(posedge clock);
            while (req_stall) @(posedge clock);
            board.note_request(stim_q.pop_front());
            burst_left--;
            if (burst_left <= 0) begin
               burst_left = $urandom_range(1, 24);
               gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 7);
            end
         end
      end
      req_valid <= 1'b0;
   endtask

   task automatic wait_drain();
      while (board.expected_q.size() > 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // memory address: mostly a small window so reads find written data,
   // some around the bounds limit, a few anywhere
   function automatic logic [BASE_W-1:0] pick_address();
      int lim;
      int a;
      lim = (int'(board.mem_size) < MEM_DEPTH_DEF) ? int'(board.mem_size) : MEM_DEPTH_DEF;
      case ($urandom_range(0, 9))
         0, 1, 2, 3, 4: a = $urandom_range(0, 15);
         5, 6, 7:       a = lim - 4 + int'($urandom_range(0, 6));
         8:             a = $urandom_range(0, 65535);
         default:       a = (lim > 0) ? int'($urandom_range(0, lim - 1)) : 0;
      endcase
      if (a < 0) a = 0;
      return BASE_W'(a);
   endfunction

   // one transaction: mostly well formed, sometimes broken or pure noise
   task automatic build_transaction();
      logic [SLAVE_W-1:0] dev;
      logic [BASE_W-1:0]  adr;
      int                 n;
      if ($urandom_range(0, 5) == 0) begin
         n = $urandom_range(1, 4);
         repeat (n) queue_event(CMD_W'($urandom_range(0, 3)), BYTE_W'($urandom));
      end else begin
         dev = ($urandom_range(0, 9) == 0) ? SLAVE_W'($urandom) : board.slave_addr;
         adr = pick_address();
         queue_event(CMD_START, BYTE_W'($urandom));
         queue_event(CMD_BYTE, {dev, 1'($urandom)});
         queue_event(CMD_BYTE, adr[15:8]);
         queue_event(CMD_BYTE, adr[7:0]);
         n = $urandom_range(1, 8);
         repeat (n) begin
            if ($urandom_range(0, 11) == 0)
               queue_event(CMD_START, BYTE_W'($urandom));
            else
               queue_event(CMD_BYTE, BYTE_W'($urandom));
         end
         // leaving out the stop makes the next start a repeated one
         if ($urandom_range(0, 5) != 0) queue_event(CMD_STOP, BYTE_W'($urandom));
      end
   endtask

   // -------------------------------------------------------------------------
   // Main sequence
   // -------------------------------------------------------------------------
   initial begin
      int phase_idx;
      int n;
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // directed, reset settings: address 80 (write 0xA1, read 0xA0), 4096 bytes
      queue_event(CMD_BYTE, 8'hFF);        // byte while idle
      queue_event(CMD_UNKNOWN, 8'h00);     // ignored command
      queue_event(CMD_START, 8'h00);
      queue_event(CMD_BYTE, 8'h00);        // address mismatch
      queue_event(CMD_START, 8'hFF);
      queue_event(CMD_BYTE, 8'hA1);
      queue_event(CMD_BYTE, 8'h0F);
      queue_event(CMD_BYTE, 8'hFF);        // last byte of memory
      queue_event(CMD_BYTE, 8'hFF);        // write at the top
      queue_event(CMD_BYTE, 8'h5A);        // runs past the end
      queue_event(CMD_START, 8'h00);       // repeated start in transfer
      queue_event(CMD_BYTE, 8'h00);        // now reads from zero
      queue_event(CMD_STOP, 8'h00);
      queue_event(CMD_START, 8'h00);
      queue_event(CMD_BYTE, 8'hA0);
      queue_event(CMD_BYTE, 8'h0F);
      queue_event(CMD_BYTE, 8'hFF);
      queue_event(CMD_BYTE, 8'h00);        // reads back the top byte
      queue_event(CMD_STOP, 8'hFF);
      send_events();
      wait_drain();

      // zero size: address and transfer both refused
      program_registers(7'd0, 13'd0);
      queue_event(CMD_START, 8'h00);
      queue_event(CMD_BYTE, 8'h01);
      queue_event(CMD_BYTE, 8'h00);
      queue_event(CMD_BYTE, 8'h00);
      queue_event(CMD_BYTE, 8'h33);
      queue_event(CMD_STOP, 8'h00);
      send_events();
      wait_drain();

      // size above the depth: address accepted, transfer clipped at the depth
      program_registers(7'd127, 13'h1FFF);
      queue_event(CMD_START, 8'h00);
      queue_event(CMD_BYTE, 8'hFF);
      queue_event(CMD_BYTE, 8'h10);
      queue_event(CMD_BYTE, 8'h00);
      queue_event(CMD_BYTE, 8'hC3);
      queue_event(CMD_STOP, 8'h00);
      send_events();
      wait_drain();

      // random phases, each under its own settings
      phase_idx = 0;
      while (board.event_count < EVENT_TARGET) begin
         case (phase_idx % 6)
            0: program_registers(SLAVE_W'($urandom), MEMORY_SIZE_RESET);
            1: program_registers(7'd0, 13'd1);
            2: program_registers(7'd127, MEMORY_SIZE_RESET);
            3: program_registers(SLAVE_W'($urandom), MSIZE_W'($urandom_range(2, 64)));
            4: program_registers(SLAVE_W'($urandom), MSIZE_W'($urandom_range(1, 4096)));
            default: program_registers(SLAVE_W'($urandom), 13'h1FFF);
         endcase
         n = $urandom_range(4, 8);
         repeat (n) build_transaction();
         send_events();
         wait_drain();
         phase_idx++;
      end

      // anything still pending at the end is a miss
      if (board.expected_q.size() > 0)
         board.report_mismatch($sformatf("%0d results never arrived",
                                         board.expected_q.size()));

      $display("Covered %0d bus events over %0d register settings: %0d acked,",
               board.event_count, settings_count + 1, board.ack_count);
      $display("%0d memory writes and %0d memory reads, %0d mismatches.",
               board.write_count, board.read_count, board.error_count);
      if (board.error_count == 0)
         $display("*** PASSED ***");
      else
         $display("*** FAILED ***");
      $finish;
   end

endmodule

// ===== files.f =====
design/i2cms_pkg.sv
design/i2cms_ram.sv
design/i2cms_engine.sv
design/i2c_memory_slave_unit.sv
design/i2cms_checker.sv
bench/testbench.sv
